@@ sv/vtp_pkg.sv @@
// ---------------------------------------------------------------------------
// vtp_pkg: shared constants and types of the vertex transform block
// widths, fixed-point formats, register indexes and the divider stage record
// ---------------------------------------------------------------------------
package vtp_pkg;

   // fixed-point formats
   localparam int COEF_FRAC_BITS = 12;
   localparam int DATA_FRAC_BITS = 16;
   localparam int DATA_W         = 32;
   localparam int COEF_W         = 16;
   localparam int NUM_COMP       = 4;
   localparam int ROW_W          = NUM_COMP * COEF_W;
   localparam int PROD_W         = DATA_W + COEF_W;
   localparam int SUM_W          = PROD_W + 2;
   localparam int NUM_W          = DATA_W + DATA_FRAC_BITS;
   localparam int REM_W          = DATA_W + 1;
   localparam int CSR_IDX_W      = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd4;

   // identity matrix after reset
   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);
   localparam logic [DATA_W-1:0] DATA_ONE = DATA_W'(1 << DATA_FRAC_BITS);

   // one divider stage: both lanes plus the values that ride alongside
   typedef struct packed {
      logic              mode;
      logic              wzero;
      logic              sat;
      logic              neg_x;
      logic              neg_y;
      logic [DATA_W-1:0] pass_x;
      logic [DATA_W-1:0] pass_y;
      logic [DATA_W-1:0] pass_z;
      logic [DATA_W-1:0] pass_w;
      logic [DATA_W-1:0] divisor;
      logic [NUM_W-1:0]  num_x;
      logic [NUM_W-1:0]  num_y;
      logic [DATA_W-1:0] rem_x;
      logic [DATA_W-1:0] rem_y;
   } div_type;

endpackage

@@ sv/vtp_if.sv @@
// ---------------------------------------------------------------------------
// vtp_if: channel interfaces of the vertex transform block
// vertex request, result response and register write channels
// ---------------------------------------------------------------------------
interface vtp_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [vtp_pkg::DATA_W-1:0]  in_x;
   logic signed [vtp_pkg::DATA_W-1:0]  in_y;
   logic signed [vtp_pkg::DATA_W-1:0]  in_z;
   logic signed [vtp_pkg::DATA_W-1:0]  in_w;
   modport source (output valid, in_x, in_y, in_z, in_w, input ready);
   modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vtp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [vtp_pkg::DATA_W-1:0]  out_x;
   logic signed [vtp_pkg::DATA_W-1:0]  out_y;
   logic signed [vtp_pkg::DATA_W-1:0]  out_z;
   logic signed [vtp_pkg::DATA_W-1:0]  out_w;
   logic                               w_was_zero;
   logic                               saturated;
   modport source (output valid, out_x, out_y, out_z, out_w, w_was_zero, saturated,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, w_was_zero, saturated,
                   output ready);
endinterface

interface vtp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [vtp_pkg::CSR_IDX_W-1:0]       index;
   logic [vtp_pkg::ROW_W-1:0]           data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/vtp_div_stage.sv @@
// ---------------------------------------------------------------------------
// vtp_div_stage: one registered step of the perspective divider
// restoring division, one quotient bit per lane per stage
// ---------------------------------------------------------------------------
module vtp_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             valid_in,
   input  vtp_pkg::div_type stage_in,
   output logic             valid_out,
   output vtp_pkg::div_type stage_out
);

   logic [vtp_pkg::REM_W-1:0] trial_x, trial_y, diff_x, diff_y, dvs;
   logic                      ge_x, ge_y;
   vtp_pkg::div_type          stage_in_w;
   vtp_pkg::div_type          stage_ff;
   logic                      valid_ff;

   // trial subtract of the divisor from the shifted remainder
   always_comb begin
      dvs     = {1'b0, stage_in.divisor};
      trial_x = {stage_in.rem_x, stage_in.num_x[vtp_pkg::NUM_W-1]};
      trial_y = {stage_in.rem_y, stage_in.num_y[vtp_pkg::NUM_W-1]};
      ge_x    = trial_x >= dvs;
      ge_y    = trial_y >= dvs;
      diff_x  = trial_x - dvs;
      diff_y  = trial_y - dvs;
      stage_in_w       = stage_in;
      stage_in_w.rem_x = ge_x ? diff_x[vtp_pkg::DATA_W-1:0] : trial_x[vtp_pkg::DATA_W-1:0];
      stage_in_w.rem_y = ge_y ? diff_y[vtp_pkg::DATA_W-1:0] : trial_y[vtp_pkg::DATA_W-1:0];
      stage_in_w.num_x = {stage_in.num_x[vtp_pkg::NUM_W-2:0], ge_x};
      stage_in_w.num_y = {stage_in.num_y[vtp_pkg::NUM_W-2:0], ge_y};
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

@@ sv/vertex_transform_project.sv @@
// ---------------------------------------------------------------------------
// vertex_transform_project: 4x4 vertex transform with perspective divide
// Q16.16 vertices times a Q4.12 matrix, optional divide of x and y by w
// ---------------------------------------------------------------------------
// One vertex is taken every clock while the pipeline is not held, and its
// result passes through these registers in order: the sixteen coefficient
// products at the accepting edge, the row sums with the rounding half, the
// floor shift, clamping and divider set-up, the stages of the pipelined
// restoring divider (one quotient bit per stage for the 48-bit dividend),
// and the result selection into the output register. The divider stages
// run in transform mode too, so the latency is the same in both modes. The
// whole pipeline holds when the result is not taken; register writes are
// accepted every cycle and should only be made while no vertex is in flight.
module vertex_transform_project (
   input  logic       clock,
   input  logic       reset,
   vtp_req_if.sink    req_chan,
   vtp_rsp_if.source  rsp_chan,
   vtp_csr_if.sink    csr_chan
);

   localparam int NC = vtp_pkg::NUM_COMP;
   localparam int DW = vtp_pkg::DATA_W;
   localparam int SW = vtp_pkg::SUM_W;
   localparam int NW = vtp_pkg::NUM_W;

   localparam logic signed [SW-1:0] S_MAX  = SW'(32'sh7fffffff);
   localparam logic signed [SW-1:0] S_MIN  = SW'(32'sh80000000);
   localparam logic signed [SW-1:0] S_HALF = SW'(1 << (vtp_pkg::COEF_FRAC_BITS - 1));
   localparam logic [NW-1:0] Q_MAX_POS = NW'(32'h7fffffff);
   localparam logic [NW-1:0] Q_MAX_NEG = NW'(32'h80000000);

   logic [vtp_pkg::ROW_W-1:0]           matrix_ff [NC];
   logic                                mode_ff;
   logic                                advance;

   logic signed [DW-1:0]                vec [NC];
   logic signed [vtp_pkg::PROD_W-1:0]   prod_in [NC][NC];
   logic signed [vtp_pkg::PROD_W-1:0]   prod_ff [NC][NC];
   logic                                v1_ff, v2_ff;
   logic signed [SW-1:0]                sum_in [NC];
   logic signed [SW-1:0]                sum_ff [NC];
   logic signed [SW-1:0]                shifted [NC];
   logic signed [DW-1:0]                clamp [NC];
   logic [NC-1:0]                       clamp_sat;

   vtp_pkg::div_type                    div_in;
   vtp_pkg::div_type                    div_pipe [NW+1];
   logic                                div_valid [NW+1];

   logic signed [DW-1:0]                res_x, res_y;
   logic                                sat_x, sat_y;
   logic                                out_valid_ff;
   logic signed [DW-1:0]                out_x_ff, out_y_ff, out_z_ff, out_w_ff;
   logic                                out_wz_ff, out_sat_ff;
   logic signed [DW-1:0]                out_x_in, out_y_in, out_z_in, out_w_in;
   logic                                out_wz_in, out_sat_in;
   vtp_pkg::div_type                    last;

   // whole pipeline moves when the output register is free or being drained
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign csr_chan.ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff[0] <= vtp_pkg::ROW_W'(vtp_pkg::COEF_ONE);
         matrix_ff[1] <= vtp_pkg::ROW_W'(vtp_pkg::COEF_ONE) << vtp_pkg::COEF_W;
         matrix_ff[2] <= vtp_pkg::ROW_W'(vtp_pkg::COEF_ONE) << (2 * vtp_pkg::COEF_W);
         matrix_ff[3] <= vtp_pkg::ROW_W'(vtp_pkg::COEF_ONE) << (3 * vtp_pkg::COEF_W);
         mode_ff      <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            vtp_pkg::CSR_ROW_0: matrix_ff[0] <= csr_chan.data;
            vtp_pkg::CSR_ROW_1: matrix_ff[1] <= csr_chan.data;
            vtp_pkg::CSR_ROW_2: matrix_ff[2] <= csr_chan.data;
            vtp_pkg::CSR_ROW_3: matrix_ff[3] <= csr_chan.data;
            vtp_pkg::CSR_MODE:  mode_ff      <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // stage 1: coefficient products
   assign vec[0] = req_chan.in_x;
   assign vec[1] = req_chan.in_y;
   assign vec[2] = req_chan.in_z;
   assign vec[3] = req_chan.in_w;

   always_comb begin
      for (int r = 0; r < NC; r++) begin
         for (int k = 0; k < NC; k++) begin
            prod_in[r][k] = vec[k] *
               $signed(matrix_ff[r][k*vtp_pkg::COEF_W +: vtp_pkg::COEF_W]);
         end
      end
   end

   // stage 2: row sums with rounding half
   always_comb begin
      for (int r = 0; r < NC; r++) begin
         sum_in[r] = SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2])
                   + SW'(prod_ff[r][3]) + S_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   // stage 3: floor shift, clamp, divider set-up
   always_comb begin
      for (int r = 0; r < NC; r++) begin
         shifted[r] = sum_ff[r] >>> vtp_pkg::COEF_FRAC_BITS;
         if (shifted[r] > S_MAX) begin
            clamp[r]     = DW'(S_MAX);
            clamp_sat[r] = 1'b1;
         end else if (shifted[r] < S_MIN) begin
            clamp[r]     = DW'(S_MIN);
            clamp_sat[r] = 1'b1;
         end else begin
            clamp[r]     = shifted[r][DW-1:0];
            clamp_sat[r] = 1'b0;
         end
      end
      div_in.mode    = mode_ff;
      div_in.wzero   = clamp[3] == '0;
      div_in.sat     = |clamp_sat;
      div_in.neg_x   = clamp[0][DW-1] ^ clamp[3][DW-1];
      div_in.neg_y   = clamp[1][DW-1] ^ clamp[3][DW-1];
      div_in.pass_x  = clamp[0];
      div_in.pass_y  = clamp[1];
      div_in.pass_z  = clamp[2];
      div_in.pass_w  = clamp[3];
      div_in.divisor = clamp[3][DW-1] ? (~clamp[3] + 1'b1) : clamp[3];
      div_in.num_x   = {(clamp[0][DW-1] ? (~clamp[0] + 1'b1) : clamp[0]),
                        {vtp_pkg::DATA_FRAC_BITS{1'b0}}};
      div_in.num_y   = {(clamp[1][DW-1] ? (~clamp[1] + 1'b1) : clamp[1]),
                        {vtp_pkg::DATA_FRAC_BITS{1'b0}}};
      div_in.rem_x   = '0;
      div_in.rem_y   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid[0] <= 1'b0;
      end else if (advance) begin
         div_valid[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_pipe[0] <= div_in;
      end
   end

   // divider stages, one quotient bit each
   for (genvar s = 0; s < NW; s++) begin : g_div
      vtp_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (div_valid[s]),
         .stage_in  (div_pipe[s]),
         .valid_out (div_valid[s+1]),
         .stage_out (div_pipe[s+1])
      );
   end

   // sign and clamp of the quotients, result selection
   assign last = div_pipe[NW];

   always_comb begin
      if (last.neg_x) begin
         sat_x = last.num_x > Q_MAX_NEG;
         res_x = sat_x ? DW'(S_MIN) : (~last.num_x[DW-1:0] + 1'b1);
      end else begin
         sat_x = last.num_x > Q_MAX_POS;
         res_x = sat_x ? DW'(S_MAX) : last.num_x[DW-1:0];
      end
      if (last.neg_y) begin
         sat_y = last.num_y > Q_MAX_NEG;
         res_y = sat_y ? DW'(S_MIN) : (~last.num_y[DW-1:0] + 1'b1);
      end else begin
         sat_y = last.num_y > Q_MAX_POS;
         res_y = sat_y ? DW'(S_MAX) : last.num_y[DW-1:0];
      end

      out_x_in   = last.pass_x;
      out_y_in   = last.pass_y;
      out_z_in   = last.pass_z;
      out_w_in   = last.pass_w;
      out_wz_in  = 1'b0;
      out_sat_in = last.sat;
      if (last.mode) begin
         out_z_in = vtp_pkg::DATA_ONE;
         out_w_in = vtp_pkg::DATA_ONE;
         if (last.wzero) begin
            out_wz_in = 1'b1;
         end else begin
            out_x_in   = res_x;
            out_y_in   = res_y;
            out_sat_in = last.sat | sat_x | sat_y;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_valid[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
         out_z_ff   <= out_z_in;
         out_w_ff   <= out_w_in;
         out_wz_ff  <= out_wz_in;
         out_sat_ff <= out_sat_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_x      = out_x_ff;
   assign rsp_chan.out_y      = out_y_ff;
   assign rsp_chan.out_z      = out_z_ff;
   assign rsp_chan.out_w      = out_w_ff;
   assign rsp_chan.w_was_zero = out_wz_ff;
   assign rsp_chan.saturated  = out_sat_ff;

endmodule
